// ----- hdl/wfd_pkg.sv -----
// Shared types and constants for the 1-D wave equation solver.
// No dependencies; used by wfd_cell, wfd_stencil and wave_equation_fdtd_1d.
package wfd_pkg;

    localparam int NODES_DEF = 64;
    localparam int IDX_W     = 6;
    localparam int DATA_W    = 24;
    localparam int ETA_W     = 17;
    localparam int TDT_W     = 24;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Q.16 fixed point one
    localparam int ONE_Q16 = 65536;

    localparam logic [ETA_W-1:0] ETA_RESET = ETA_W'(16384);
    localparam logic [TDT_W-1:0] TDT_RESET = TDT_W'(65536);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic {
        REG_ETA_SQUARED = 1'b0,
        REG_TWO_DT      = 1'b1
    } reg_idx_t;

    typedef logic signed [DATA_W-1:0] data_t;

    // One node's state as it travels around the ring
    typedef struct packed {
        data_t cur;
        data_t prev;
        data_t vel;
    } cell_t;

    // Control that rides along with a node through the stencil pipeline
    typedef struct packed {
        logic             valid;
        logic             interior;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

// ----- hdl/wave_equation_fdtd_1d.sv -----
// Top level of the 1-D explicit wave equation solver: ring of node cells,
// stencil pipeline, APB registers. Depends on wfd_pkg, wfd_cell, wfd_stencil.
//
// Usage
//   s_ channel carries one transaction per command. action = load writes the
//   displacement and start velocity of node s_node_index (indexes >= NODES are
//   dropped), emits nothing and re-arms the first-step formula.
//   action = step advances all NODES nodes one time step and emits NODES
//   transactions on m_, node 0 first, m_last on node NODES-1.
//   Nodes 0, 1, NODES-2 and NODES-1 are held at zero after every step.
// Stepping
//   A step rotates the node ring once, one node per cycle unless a held result
//   stalls it, through a single stencil datapath with two register stages.
//   The next command is accepted once the pipeline has drained.
// Reset
//   aresetn (synchronous, active low) zeroes all node state, sets the
//   first-step flag, eta_squared = 0.25 and two_dt = 1.0.
// Stall
//   When m_ready is low with a result pending, ring and pipeline freeze;
//   nothing is lost. s_ready stays low until the last result is taken.
// Registers (APB, pready always high)
//   0x0 eta_squared (Q1.16), 0x4 two_dt (Q8.16). Write only while idle.
module wave_equation_fdtd_1d #(
    parameter int NODES = wfd_pkg::NODES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [wfd_pkg::IDX_W-1:0]       s_node_index,
    input  logic signed [wfd_pkg::DATA_W-1:0] s_displacement,
    input  logic signed [wfd_pkg::DATA_W-1:0] s_velocity,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wfd_pkg::IDX_W-1:0]       m_node_index_res,
    output logic signed [wfd_pkg::DATA_W-1:0] m_displacement_res,
    output logic                            m_last,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wfd_pkg::APB_AW-1:0]      paddr,
    input  logic [wfd_pkg::APB_DW-1:0]      pwdata,
    output logic [wfd_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int IW = wfd_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(NODES - 1);
    localparam logic [IW-1:0] FIRST_INT = IW'(2);
    localparam logic [IW-1:0] LAST_INT  = IW'(NODES - 3);
    localparam logic [IW:0]   NODES_L   = (IW + 1)'(NODES);
    // ring position whose cur takes the stencil result (node is two
    // positions past the wrap when its result leaves stage 2)
    localparam int WB_CELL = NODES - 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                      state_reg;
    logic [IW-1:0]               k_reg;
    logic                        pending_reg;
    logic [wfd_pkg::ETA_W-1:0]   eta_reg;
    logic [wfd_pkg::TDT_W-1:0]   two_dt_reg;

    wfd_pkg::cell_t cell_q [NODES];
    wfd_pkg::cell_t cell_d [NODES];

    wfd_pkg::tag_t  in_tag;
    wfd_pkg::tag_t  out_tag;
    wfd_pkg::data_t out_res;
    logic           pipe_busy;

    logic in_fire;
    logic load_fire;
    logic step_fire;
    logic advance;
    logic shift_en;
    logic wb_en;
    logic cfg_wr;

    // ------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_action == wfd_pkg::ACT_LOAD)
                       && ({1'b0, s_node_index} < NODES_L);
    assign step_fire = in_fire && (s_action == wfd_pkg::ACT_STEP);

    // whole ring + pipeline moves together; blocked only by a held result
    assign advance  = !out_tag.valid || m_ready;
    assign shift_en = (state_reg == ST_RUN) && advance;
    assign wb_en    = shift_en && out_tag.valid && out_tag.interior;

    // ------------------------------------------------------------------
    // Sequencer: one ring rotation per step, then let the pipe empty
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            pending_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (load_fire) begin
                        pending_reg <= 1'b1;
                    end
                    if (step_fire) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (advance) begin
                        k_reg <= k_reg + IW'(1);
                        if (k_reg == LAST_IDX) begin
                            state_reg   <= ST_DRAIN;
                            pending_reg <= 1'b0;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_reg    <= wfd_pkg::ETA_RESET;
            two_dt_reg <= wfd_pkg::TDT_RESET;
        end else if (cfg_wr) begin
            case (wfd_pkg::reg_idx_t'(paddr[2]))
                wfd_pkg::REG_ETA_SQUARED: eta_reg    <= pwdata[wfd_pkg::ETA_W-1:0];
                wfd_pkg::REG_TWO_DT:      two_dt_reg <= pwdata[wfd_pkg::TDT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wfd_pkg::reg_idx_t'(paddr[2]))
            wfd_pkg::REG_ETA_SQUARED:
                prdata = wfd_pkg::APB_DW'(eta_reg);
            wfd_pkg::REG_TWO_DT:
                prdata = wfd_pkg::APB_DW'(two_dt_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Node ring. Idle: cell i holds node i. Each step cycle everything moves
    // one place toward cell 0; cell 0 wraps into the tail carrying its old
    // cur into prev (cur cleared, edges stay zero). Interior results are
    // dropped into cur at WB_CELL two places further on.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NODES; i++) begin : g_cell
        if (i == NODES - 1) begin : g_tail
            always_comb begin
                cell_d[i].cur  = '0;
                cell_d[i].prev = cell_q[0].cur;
                cell_d[i].vel  = cell_q[0].vel;
            end
        end else if (i == WB_CELL) begin : g_wb
            always_comb begin
                cell_d[i] = cell_q[i+1];
                if (wb_en) begin
                    cell_d[i].cur = out_res;
                end
            end
        end else begin : g_mid
            assign cell_d[i] = cell_q[i+1];
        end

        wfd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_fire && (s_node_index == IW'(i))),
            .load_disp (s_displacement),
            .load_vel  (s_velocity),
            .shift_en  (shift_en),
            .d_in      (cell_d[i]),
            .q         (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Stencil window: centre at cell 0, right at cell 1, left is the node
    // that just wrapped (its old cur sits in the tail's prev).
    // ------------------------------------------------------------------
    always_comb begin
        in_tag.valid    = (state_reg == ST_RUN);
        in_tag.idx      = k_reg;
        in_tag.last     = (k_reg == LAST_IDX);
        in_tag.interior = (k_reg >= FIRST_INT) && (k_reg <= LAST_INT);
    end

    wfd_stencil u_stencil (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_tag  (in_tag),
        .first   (pending_reg),
        .eta     (eta_reg),
        .two_dt  (two_dt_reg),
        .left    (cell_q[NODES-1].prev),
        .centre  (cell_q[0]),
        .right   (cell_q[1].cur),
        .out_tag (out_tag),
        .out_res (out_res),
        .busy    (pipe_busy)
    );

    assign m_valid            = out_tag.valid;
    assign m_node_index_res   = out_tag.idx;
    assign m_displacement_res = out_res;
    assign m_last             = out_tag.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_node_index_res == LAST_IDX)
        else $error("last flag on wrong node");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("command accepted with results still pending");

    a_edge_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_node_index_res < FIRST_INT || m_node_index_res > LAST_INT)
        |-> m_displacement_res == '0)
        else $error("edge node not zero");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> !s_ready && state_reg == ST_RUN)
        else $error("step transaction did not start a rotation");

endmodule

// ----- hdl/wfd_cell.sv -----
// One ring cell: holds current, previous displacement and start velocity of one node.
// Depends on wfd_pkg (cell_t, data_t).
module wfd_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load_en,
    input  wfd_pkg::data_t load_disp,
    input  wfd_pkg::data_t load_vel,
    input  logic           shift_en,
    input  wfd_pkg::cell_t d_in,
    output wfd_pkg::cell_t q
);

    wfd_pkg::cell_t cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (load_en) begin
            // load leaves the previous row alone
            cell_reg.cur <= load_disp;
            cell_reg.vel <= load_vel;
        end else if (shift_en) begin
            cell_reg <= d_in;
        end
    end

    assign q = cell_reg;

endmodule

// ----- hdl/wfd_stencil.sv -----
// Two-stage stencil datapath: products, then sum / round / saturate into the
// output register. Depends on wfd_pkg (cell_t, tag_t, widths).
module wfd_stencil (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  wfd_pkg::tag_t                 in_tag,
    input  logic                          first,
    input  logic [wfd_pkg::ETA_W-1:0]     eta,
    input  logic [wfd_pkg::TDT_W-1:0]     two_dt,
    input  wfd_pkg::data_t                left,
    input  wfd_pkg::cell_t                centre,
    input  wfd_pkg::data_t                right,
    output wfd_pkg::tag_t                 out_tag,
    output wfd_pkg::data_t                out_res,
    output logic                          busy
);

    localparam int DW    = wfd_pkg::DATA_W;
    localparam int SIDE_W = DW + 1;
    localparam int COEF_W = wfd_pkg::ETA_W + 2;
    localparam int PA_W  = wfd_pkg::ETA_W + 1 + SIDE_W;
    localparam int PB_W  = COEF_W + DW;
    localparam int PC_W  = wfd_pkg::TDT_W + 1 + DW;
    localparam int ACC_W = PC_W + 2;
    localparam int Q_W   = ACC_W - 16;

    localparam logic signed [COEF_W-1:0] COEF_FIRST = COEF_W'(wfd_pkg::ONE_Q16);
    localparam logic signed [COEF_W-1:0] COEF_NORM  = COEF_W'(2 * wfd_pkg::ONE_Q16);
    localparam logic signed [Q_W-1:0]    SAT_MAX    = Q_W'((1 << (DW - 1)) - 1);
    localparam logic signed [Q_W-1:0]    SAT_MIN    = -Q_W'(1 << (DW - 1));
    localparam logic signed [ACC_W-1:0]  HALF_LSB   = ACC_W'(wfd_pkg::ONE_Q16 / 2);

    logic signed [SIDE_W-1:0]        side;
    logic signed [wfd_pkg::ETA_W:0]  eta_s;
    logic signed [COEF_W-1:0]        coef;
    logic signed [PC_W-1:0]          prev_ext;
    logic signed [PC_W-1:0]          vel_prod;
    logic signed [PA_W-1:0]          pa_next, pa_reg;
    logic signed [PB_W-1:0]          pb_next, pb_reg;
    logic signed [PC_W-1:0]          pc_next, pc_reg;
    logic signed [ACC_W-1:0]         acc;
    logic signed [Q_W-1:0]           q_val;
    wfd_pkg::data_t                  res_next, res_reg;
    wfd_pkg::tag_t                   p1_tag_reg, p2_tag_reg;

    // stage 1: two products and a third term (velocity product on the first step, else -prev shifted to Q.16)
    always_comb begin
        side     = SIDE_W'(left) + SIDE_W'(right);
        eta_s    = $signed({1'b0, eta});
        coef     = (first ? COEF_FIRST : COEF_NORM) - $signed({1'b0, eta, 1'b0});
        prev_ext = PC_W'(centre.prev);
        vel_prod = $signed({1'b0, two_dt}) * centre.vel;
        pa_next  = eta_s * side;
        pb_next  = coef * centre.cur;
        pc_next  = first ? vel_prod : -(prev_ext <<< 16);
    end

    // stage 2: exact sum, round half up from Q.16, saturate; non-interior nodes give zero
    always_comb begin
        acc   = ACC_W'(pa_reg) + ACC_W'(pb_reg) + ACC_W'(pc_reg) + HALF_LSB;
        q_val = acc[ACC_W-1:16];
        if (!p1_tag_reg.interior) begin
            res_next = '0;
        end else if (q_val > SAT_MAX) begin
            res_next = DW'(SAT_MAX);
        end else if (q_val < SAT_MIN) begin
            res_next = DW'(SAT_MIN);
        end else begin
            res_next = DW'(q_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_tag_reg <= '0;
            p2_tag_reg <= '0;
        end else if (advance) begin
            p1_tag_reg <= in_tag;
            p2_tag_reg <= p1_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            res_reg <= res_next;
        end
    end

    assign out_tag = p2_tag_reg;
    assign out_res = res_reg;
    assign busy    = p1_tag_reg.valid | p2_tag_reg.valid;

endmodule
